// ===== hdl/stack_vm_instruction_executor_core_macros.svh =====
// Assertion macros for the stack VM executor.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

`define SVIE_ASSERT_COMB(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define SVIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/svie_pkg.sv =====
// Shared opcodes, unit codes and port structs for the stack VM executor.
// No dependencies.
package svie_pkg;

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_EXIT = 6'd37;

    localparam logic [1:0] MD_MUL = 2'd0;
    localparam logic [1:0] MD_DIV = 2'd1;
    localparam logic [1:0] MD_REM = 2'd2;

    typedef struct packed {
        logic        en;
        logic [7:0]  be;
        logic [63:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  kind;
        logic [63:0] a;
        logic [63:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } md_rsp_t;

endpackage

// ===== hdl/svie_mem.sv =====
// Data memory: 64-bit words, byte-enable write, two registered reads (word, word+1).
// Clears itself after reset. Depends on svie_pkg.
module svie_mem #(
    parameter int WORDS = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [$clog2(WORDS)-1:0]   wr_addr,
    input  svie_pkg::mem_wr_t          wr,
    input  logic [$clog2(WORDS)-1:0]   rd_addr,
    output logic [63:0]                rd_lo,
    output logic [63:0]                rd_hi,
    output logic                       clr_busy
);
    import svie_pkg::*;

    localparam int WW = $clog2(WORDS);

    logic [63:0]   mem [WORDS];
    logic          clr_reg;
    logic [WW-1:0] clr_idx_reg;
    logic [WW-1:0] rd_addr_p1;
    logic [63:0]   rd_lo_reg;
    logic [63:0]   rd_hi_reg;

    assign rd_addr_p1 = rd_addr + WW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end else if (clr_reg) begin
            clr_idx_reg <= clr_idx_reg + WW'(1);
            if (clr_idx_reg == WW'(WORDS - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr.en) begin
            for (int i = 0; i < 8; i++) begin
                if (wr.be[i]) begin
                    mem[wr_addr][8*i +: 8] <= wr.data[8*i +: 8];
                end
            end
        end
        rd_lo_reg <= mem[rd_addr];
        rd_hi_reg <= mem[rd_addr_p1];
    end

    assign rd_lo    = rd_lo_reg;
    assign rd_hi    = rd_hi_reg;
    assign clr_busy = clr_reg;

endmodule

// ===== hdl/svie_muldiv.sv =====
// Multi-cycle multiply (three 32x32 partial products) and radix-2 signed divide.
// Depends on svie_pkg.
module svie_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  svie_pkg::md_req_t req,
    output svie_pkg::md_rsp_t rsp
);
    import svie_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  kind_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [63:0] ma_reg;
    logic [63:0] mb_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] res_reg;

    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic [64:0] trial;
    logic        ge;
    logic [64:0] diff;
    logic [63:0] rem_step;
    logic [63:0] q_step;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0:    begin mx = ma_reg[31:0];  my = mb_reg[31:0];  end
            2'd1:    begin mx = ma_reg[31:0];  my = mb_reg[63:32]; end
            default: begin mx = ma_reg[63:32]; my = mb_reg[31:0];  end
        endcase
        prod     = 64'(mx) * 64'(my);
        trial    = {rem_reg, q_reg[63]};
        diff     = trial - {1'b0, mb_reg};
        ge       = !diff[64];
        rem_step = ge ? diff[63:0] : trial[63:0];
        q_step   = {q_reg[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                kind_reg <= req.kind;
                cnt_reg  <= '0;
                if (req.kind == MD_MUL) begin
                    ma_reg   <= req.a;
                    mb_reg   <= req.b;
                    q_reg    <= '0;
                    busy_reg <= 1'b1;
                end else begin
                    ma_reg    <= req.a[63] ? 64'(0) - req.a : req.a;
                    mb_reg    <= req.b[63] ? 64'(0) - req.b : req.b;
                    q_reg     <= req.a[63] ? 64'(0) - req.a : req.a;
                    rem_reg   <= '0;
                    neg_q_reg <= req.a[63] ^ req.b[63];
                    neg_r_reg <= req.a[63];
                    if (req.b == '0) begin
                        res_reg  <= (req.kind == MD_REM) ? req.a : '1;
                        done_reg <= 1'b1;
                    end else begin
                        busy_reg <= 1'b1;
                    end
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (kind_reg == MD_MUL) begin
                    if (cnt_reg == 6'd0) begin
                        q_reg <= prod;
                    end else begin
                        q_reg <= q_reg + {prod[31:0], 32'b0};
                    end
                    if (cnt_reg == 6'd2) begin
                        res_reg  <= q_reg + {prod[31:0], 32'b0};
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end else begin
                    rem_reg <= rem_step;
                    q_reg   <= q_step;
                    if (cnt_reg == 6'd63) begin
                        if (kind_reg == MD_REM) begin
                            res_reg <= neg_r_reg ? 64'(0) - rem_step : rem_step;
                        end else begin
                            res_reg <= neg_q_reg ? 64'(0) - q_step : q_step;
                        end
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== hdl/stack_vm_instruction_executor_core.sv =====
// Stack VM executor: one instruction word in, one status word out.
// States per word: S_DEC, then S_OUT if no memory is touched; LI/LC/EXIT and pops go through
// S_RD and S_USE, SI/SC then write in S_WR1 (and S_WR2); CALL/ENT/PUSH write the same way;
// LEV reads twice; MUL/DIV/MOD wait in S_MD for the shared muldiv unit, which skips the divide
// on a zero divisor. A stalled m_tready holds the word and blocks s_tready. The single write
// port makes a misaligned 64-bit store take two writes. After reset the data memory clears
// one word per cycle, all MEM_BYTES/8 words, with s_tready low. MEM_BYTES and TEXT_WORDS must
// be powers of two. After a halt each word is answered with the unchanged status.
`include "stack_vm_instruction_executor_core_macros.svh"
module stack_vm_instruction_executor_core #(
    parameter int MEM_BYTES  = 8192,
    parameter int TEXT_WORDS = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // func[5:0], operand[69:6], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata    // next_pc[15:0], acc_value[79:16], halted[80],
                                    // fault[81], exit_code[145:82], zero pad
);
    import svie_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(TEXT_WORDS);
    localparam int WW = AW - 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_USE  = 3'd3;
    localparam logic [2:0] S_WR1  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_MD   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [5:0]    op_reg, op_next;
    logic [63:0]   opd_reg, opd_next;
    logic [63:0]   acc_reg, acc_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [AW-1:0] sp_reg, sp_next;
    logic [AW-1:0] bp_reg, bp_next;
    logic          stopped_reg, stopped_next;
    logic          fault_reg, fault_next;
    logic [63:0]   exit_reg, exit_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [63:0]   wd_reg, wd_next;
    logic          wbyte_reg, wbyte_next;
    logic          ph_reg, ph_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [151:0]  m_tdata_reg, m_tdata_next;

    logic [63:0]   rd_lo, rd_hi;
    logic          clr_busy;
    mem_wr_t       mem_wr;
    logic [WW-1:0] mem_wa;
    md_req_t       md_req;
    md_rsp_t       md_rsp;

    logic [127:0]  ld_wide;
    logic [63:0]   ld64;
    logic [127:0]  st_wide;
    logic [15:0]   st_be;
    logic [PW-1:0] seq1, seq2, jtgt;
    logic [AW-1:0] opd8, spm8, lea_addr;
    logic [31:0]   pc32;

    function automatic logic [63:0] sext8(input logic [63:0] v);
        return {{56{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [63:0] alu(input logic [5:0] op, input logic [63:0] l,
                                        input logic [63:0] r);
        logic [63:0] res;
        unique case (op)
            OP_OR:   res = l | r;
            OP_XOR:  res = l ^ r;
            OP_AND:  res = l & r;
            OP_EQ:   res = 64'(l == r);
            OP_NE:   res = 64'(l != r);
            OP_LT:   res = 64'($signed(l) < $signed(r));
            OP_GT:   res = 64'($signed(r) < $signed(l));
            OP_LE:   res = 64'(!($signed(r) < $signed(l)));
            OP_GE:   res = 64'(!($signed(l) < $signed(r)));
            OP_SHL:  res = l << r[5:0];
            OP_SHR:  res = $unsigned($signed(l) >>> r[5:0]);
            OP_ADD:  res = l + r;
            OP_SUB:  res = l - r;
            default: res = '0;
        endcase
        return res;
    endfunction

    svie_mem #(.WORDS(MEM_BYTES / 8)) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_addr  (mem_wa),
        .wr       (mem_wr),
        .rd_addr  (addr_reg[AW-1:3]),
        .rd_lo    (rd_lo),
        .rd_hi    (rd_hi),
        .clr_busy (clr_busy)
    );

    svie_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign ld_wide  = {rd_hi, rd_lo} >> {addr_reg[2:0], 3'b000};
    assign ld64     = ld_wide[63:0];
    assign st_wide  = (wbyte_reg ? {120'b0, wd_reg[7:0]} : {64'b0, wd_reg})
                      << {wa_reg[2:0], 3'b000};
    assign st_be    = (wbyte_reg ? 16'h0001 : 16'h00FF) << wa_reg[2:0];
    assign seq1     = pc_reg + PW'(1);
    assign seq2     = pc_reg + PW'(2);
    assign jtgt     = opd_reg[PW-1:0];
    assign opd8     = {opd_reg[AW-4:0], 3'b000};
    assign spm8     = sp_reg - AW'(8);
    assign lea_addr = bp_reg + opd8;
    assign pc32     = 32'(pc_reg);

    always_comb begin
        mem_wr.en   = (state_reg == S_WR1) || (state_reg == S_WR2);
        mem_wr.be   = (state_reg == S_WR2) ? st_be[15:8] : st_be[7:0];
        mem_wr.data = (state_reg == S_WR2) ? st_wide[127:64] : st_wide[63:0];
        mem_wa      = (state_reg == S_WR2) ? wa_reg[AW-1:3] + WW'(1) : wa_reg[AW-1:3];
    end

    assign s_tready = (state_reg == S_IDLE) && !clr_busy;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        opd_next      = opd_reg;
        acc_next      = acc_reg;
        pc_next       = pc_reg;
        sp_next       = sp_reg;
        bp_next       = bp_reg;
        stopped_next  = stopped_reg;
        fault_next    = fault_reg;
        exit_next     = exit_reg;
        addr_next     = addr_reg;
        wa_next       = wa_reg;
        wd_next       = wd_reg;
        wbyte_next    = wbyte_reg;
        ph_next       = ph_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        md_req.start  = 1'b0;
        md_req.kind   = MD_MUL;
        md_req.a      = ld64;
        md_req.b      = acc_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next    = s_tdata[5:0];
                    opd_next   = s_tdata[69:6];
                    state_next = stopped_reg ? S_OUT : S_DEC;
                end
            end
            S_DEC: begin
                pc_next    = seq1;
                wbyte_next = 1'b0;
                state_next = S_OUT;
                unique case (op_reg)
                    OP_LEA: begin acc_next = 64'(lea_addr); pc_next = seq2; end
                    OP_IMM: begin acc_next = opd_reg; pc_next = seq2; end
                    OP_JMP: pc_next = jtgt;
                    OP_CALL: begin
                        sp_next    = spm8;
                        wa_next    = spm8;
                        wd_next    = 64'(seq2);
                        pc_next    = jtgt;
                        state_next = S_WR1;
                    end
                    OP_JZ:  pc_next = (acc_reg == '0) ? jtgt : seq2;
                    OP_JNZ: pc_next = (acc_reg != '0) ? jtgt : seq2;
                    OP_ENT: begin
                        wa_next    = spm8;
                        wd_next    = 64'(bp_reg);
                        bp_next    = spm8;
                        sp_next    = spm8 - opd8;
                        pc_next    = seq2;
                        state_next = S_WR1;
                    end
                    OP_ADJ: begin sp_next = sp_reg + opd8; pc_next = seq2; end
                    OP_LEV: begin
                        sp_next    = bp_reg;
                        addr_next  = bp_reg;
                        ph_next    = 1'b0;
                        state_next = S_RD;
                    end
                    OP_LI, OP_LC: begin
                        addr_next  = acc_reg[AW-1:0];
                        state_next = S_RD;
                    end
                    OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT,
                    OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                    OP_MOD: begin
                        addr_next  = sp_reg;
                        state_next = S_RD;
                    end
                    OP_EXIT: begin
                        pc_next    = pc_reg;
                        addr_next  = sp_reg;
                        state_next = S_RD;
                    end
                    OP_PUSH: begin
                        sp_next    = spm8;
                        wa_next    = spm8;
                        wd_next    = acc_reg;
                        state_next = S_WR1;
                    end
                    default: begin
                        pc_next      = pc_reg;
                        stopped_next = 1'b1;
                        fault_next   = 1'b1;
                        exit_next    = '1;
                    end
                endcase
            end
            S_RD: state_next = S_USE;
            S_USE: begin
                sp_next    = sp_reg + AW'(8);
                state_next = S_OUT;
                unique case (op_reg)
                    OP_LEV: begin
                        sp_next = addr_reg + AW'(8);
                        if (!ph_reg) begin
                            bp_next    = ld64[AW-1:0];
                            addr_next  = addr_reg + AW'(8);
                            ph_next    = 1'b1;
                            state_next = S_RD;
                        end else begin
                            pc_next = ld64[PW-1:0];
                        end
                    end
                    OP_LI: begin sp_next = sp_reg; acc_next = ld64; end
                    OP_LC: begin sp_next = sp_reg; acc_next = sext8(ld64); end
                    OP_SI: begin
                        wa_next    = ld64[AW-1:0];
                        wd_next    = acc_reg;
                        wbyte_next = 1'b0;
                        state_next = S_WR1;
                    end
                    OP_SC: begin
                        wa_next    = ld64[AW-1:0];
                        wd_next    = acc_reg;
                        wbyte_next = 1'b1;
                        acc_next   = sext8(acc_reg);
                        state_next = S_WR1;
                    end
                    OP_EXIT: begin
                        sp_next      = sp_reg;
                        stopped_next = 1'b1;
                        exit_next    = ld64;
                    end
                    OP_MUL, OP_DIV, OP_MOD: begin
                        md_req.start = 1'b1;
                        md_req.kind  = (op_reg == OP_MUL) ? MD_MUL :
                                       (op_reg == OP_DIV) ? MD_DIV : MD_REM;
                        state_next   = S_MD;
                    end
                    default: acc_next = alu(op_reg, ld64, acc_reg);
                endcase
            end
            S_WR1: state_next = (st_be[15:8] != 8'h00) ? S_WR2 : S_OUT;
            S_WR2: state_next = S_OUT;
            S_MD: begin
                if (md_rsp.done) begin
                    acc_next   = md_rsp.result;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, (stopped_reg ? exit_reg : 64'(0)), fault_reg,
                                     stopped_reg, acc_reg, pc32[15:0]};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            acc_reg      <= '0;
            pc_reg       <= '0;
            sp_reg       <= '0;
            bp_reg       <= '0;
            stopped_reg  <= 1'b0;
            fault_reg    <= 1'b0;
            exit_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            pc_reg       <= pc_next;
            sp_reg       <= sp_next;
            bp_reg       <= bp_next;
            stopped_reg  <= stopped_next;
            fault_reg    <= fault_next;
            exit_reg     <= exit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        opd_reg     <= opd_next;
        addr_reg    <= addr_next;
        wa_reg      <= wa_next;
        wd_reg      <= wd_next;
        wbyte_reg   <= wbyte_next;
        ph_reg      <= ph_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SVIE_ASSERT_COMB(a_no_accept_in_clear, clr_busy, !s_tready, "word accepted during clear")
    `SVIE_ASSERT_NEXT(a_halt_sticky, stopped_reg, stopped_reg, "halt flag dropped")
    `SVIE_ASSERT_COMB(a_fault_halts, fault_reg, stopped_reg, "fault set without halt")
    `SVIE_ASSERT_COMB(a_md_done_in_wait, md_rsp.done, state_reg == S_MD, "stray muldiv result")

endmodule

// ===== test/tb_stack_vm_instruction_executor_core.sv =====
// Self-checking testbench for stack_vm_instruction_executor_core.
// Drives instruction words, predicts each status word, compares them in order.
// Depends on svie_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_stack_vm_instruction_executor_core;
    import svie_pkg::*;

    // packed from the highest bit down, so the last field sits in the lowest bits
    typedef struct packed {
        logic [63:0] operand;
        logic [5:0]  func;
    } insn_t;

    typedef struct packed {
        logic [63:0] exit_code;
        logic        fault;
        logic        halted;
        logic [63:0] acc_value;
        logic [15:0] next_pc;
    } status_t;

    localparam int MEM_SZ      = 8192;
    localparam int WDOG_LIMIT  = 6000;
    localparam int DRAIN_AT    = 600;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;

    stack_vm_instruction_executor_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    insn_t   insn_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      offered = 0;
    int      results = 0;

    // machine copy
    logic [63:0] vm_acc = '0;
    logic [15:0] vm_pc = '0;
    logic [12:0] vm_sp = '0;
    logic [12:0] vm_bp = '0;
    logic [7:0]  vm_mem [MEM_SZ];
    logic        vm_stop = 1'b0;
    logic        vm_fault = 1'b0;
    logic [63:0] vm_exit = '0;

    initial foreach (vm_mem[i]) vm_mem[i] = 8'h00;

    function automatic logic [63:0] rd_word(logic [12:0] a);
        logic [63:0] v;
        for (int i = 0; i < 8; i++) v[8*i +: 8] = vm_mem[13'(a + i)];
        return v;
    endfunction

    function automatic void wr_word(logic [12:0] a, logic [63:0] v);
        for (int i = 0; i < 8; i++) vm_mem[13'(a + i)] = v[8*i +: 8];
    endfunction

    function automatic void push_word(logic [63:0] v);
        vm_sp = vm_sp - 13'd8;
        wr_word(vm_sp, v);
    endfunction

    function automatic logic [63:0] pop_word();
        logic [63:0] v;
        v = rd_word(vm_sp);
        vm_sp = vm_sp + 13'd8;
        return v;
    endfunction

    function automatic logic [63:0] sx8(logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic status_t execute(insn_t w);
        logic [15:0] seq1, seq2, npc;
        logic [63:0] l, opd;
        longint sl, sa;
        status_t s;
        opd = w.operand;
        seq1 = vm_pc + 16'd1;
        seq2 = vm_pc + 16'd2;
        npc = seq1;
        if (!vm_stop) begin
            case (w.func)
                OP_LEA: begin
                    vm_acc = 64'(13'(vm_bp + {opd[9:0], 3'b0})); npc = seq2;
                end
                OP_IMM: begin vm_acc = opd; npc = seq2; end
                OP_JMP: npc = opd[15:0];
                OP_CALL: begin push_word(64'(seq2)); npc = opd[15:0]; end
                OP_JZ: npc = (vm_acc != 0) ? seq2 : opd[15:0];
                OP_JNZ: npc = (vm_acc != 0) ? opd[15:0] : seq2;
                OP_ENT: begin
                    push_word(64'(vm_bp));
                    vm_bp = vm_sp;
                    vm_sp = vm_sp - {opd[9:0], 3'b0};
                    npc = seq2;
                end
                OP_ADJ: begin vm_sp = vm_sp + {opd[9:0], 3'b0}; npc = seq2; end
                OP_LEV: begin
                    vm_sp = vm_bp;
                    vm_bp = 13'(pop_word());
                    npc = 16'(pop_word());
                end
                OP_LI: vm_acc = rd_word(vm_acc[12:0]);
                OP_LC: vm_acc = sx8(vm_mem[vm_acc[12:0]]);
                OP_SI: begin l = pop_word(); wr_word(l[12:0], vm_acc); end
                OP_SC: begin
                    l = pop_word();
                    vm_mem[l[12:0]] = vm_acc[7:0];
                    vm_acc = sx8(vm_acc[7:0]);
                end
                OP_PUSH: push_word(vm_acc);
                OP_EXIT: begin
                    vm_stop = 1'b1; vm_exit = rd_word(vm_sp); npc = vm_pc;
                end
                default: begin
                    if (w.func >= OP_OR && w.func <= OP_MOD) begin
                        l = pop_word();
                        sl = l;
                        sa = vm_acc;
                        case (w.func)
                            OP_OR:  vm_acc = l | vm_acc;
                            OP_XOR: vm_acc = l ^ vm_acc;
                            OP_AND: vm_acc = l & vm_acc;
                            OP_EQ:  vm_acc = 64'(l == vm_acc);
                            OP_NE:  vm_acc = 64'(l != vm_acc);
                            OP_LT:  vm_acc = 64'(sl < sa);
                            OP_GT:  vm_acc = 64'(sl > sa);
                            OP_LE:  vm_acc = 64'(sl <= sa);
                            OP_GE:  vm_acc = 64'(sl >= sa);
                            OP_SHL: vm_acc = l << vm_acc[5:0];
                            OP_SHR: vm_acc = sl >>> vm_acc[5:0];
                            OP_ADD: vm_acc = l + vm_acc;
                            OP_SUB: vm_acc = l - vm_acc;
                            OP_MUL: vm_acc = l * vm_acc;
                            OP_DIV: begin
                                if (sa == 0) vm_acc = '1;
                                else if (sa == -1) vm_acc = -l;
                                else vm_acc = sl / sa;
                            end
                            default: begin
                                if (sa == 0) vm_acc = l;
                                else if (sa == -1) vm_acc = '0;
                                else vm_acc = sl % sa;
                            end
                        endcase
                    end else begin
                        vm_stop = 1'b1; vm_fault = 1'b1; vm_exit = '1; npc = vm_pc;
                    end
                end
            endcase
            vm_pc = npc;
        end
        s.next_pc = vm_pc;
        s.acc_value = vm_acc;
        s.halted = vm_stop;
        s.fault = vm_fault;
        s.exit_code = vm_stop ? vm_exit : 64'd0;
        return s;
    endfunction

    // sender
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                status_q.push_back(execute(s_tdata[69:0]));
            if (!s_tvalid || s_tready) begin
                if (offered == DRAIN_AT && (status_q.size() != 0 || (s_tvalid && s_tready))) begin
                    s_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (insn_q.size() != 0) begin
                    s_tdata <= {2'b00, insn_q.pop_front()};
                    s_tvalid <= 1'b1;
                    offered <= offered + 1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    int hold_left = 0;
    bit hold_done = 0;
    int mode_cnt = 0;
    bit stall_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            mode_cnt <= mode_cnt + 1;
            if (mode_cnt % 64 == 0) stall_mode <= $urandom_range(0, 1);
            if (!hold_done && results == HOLD_AT) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[145:0];
            results <= results + 1;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: pc %h/%h acc %h/%h halt %b/%b flt %b/%b exit %h/%h",
                                 want.next_pc, got.next_pc, want.acc_value, got.acc_value,
                                 want.halted, got.halted, want.fault, got.fault,
                                 want.exit_code, got.exit_code);
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[stack_vm_instruction_executor_core] ERROR");
            $finish;
        end
    end

    function automatic void add_insn(logic [5:0] f, logic [63:0] o);
        insn_t w;
        w.func = f;
        w.operand = o;
        insn_q.push_back(w);
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'(longint'($urandom_range(0, 40)) - 20);
            2: return 64'($urandom_range(0, MEM_SZ - 1));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    initial begin
        logic [5:0] f;
        add_insn(OP_IMM, 64'h8000_0000_0000_0000);
        add_insn(OP_PUSH, '1);
        add_insn(OP_IMM, '1);
        add_insn(OP_DIV, 64'h7FFF_FFFF_FFFF_FFFF);
        add_insn(OP_PUSH, 64'd0);
        add_insn(OP_IMM, 64'd0);
        add_insn(OP_MOD, 64'd0);
        add_insn(OP_PUSH, 64'd0);
        add_insn(OP_DIV, 64'd0);
        add_insn(OP_PUSH, 64'd0);
        add_insn(OP_IMM, 64'd67);
        add_insn(OP_SHR, 64'd0);
        add_insn(OP_LEA, -64'sd3);
        add_insn(OP_PUSH, 64'd0);
        add_insn(OP_IMM, 64'h1FF);
        add_insn(OP_SC, 64'd0);
        add_insn(OP_LC, 64'd0);
        add_insn(OP_CALL, 64'hFFFF_FFFF_FFFF_FFF0);
        add_insn(OP_ENT, 64'd2);
        add_insn(OP_LEA, 64'd1);
        add_insn(OP_PUSH, 64'd0);
        add_insn(OP_SI, 64'd0);
        add_insn(OP_LI, 64'd0);
        add_insn(OP_ADJ, -64'sd1);
        add_insn(OP_LEV, 64'd0);
        add_insn(OP_JZ, 64'd5);
        add_insn(OP_JNZ, 64'd9);
        for (int i = 0; i < 1100; i++) begin
            f = ($urandom_range(0, 4) == 0) ? OP_PUSH : 6'($urandom_range(0, 29));
            add_insn(f, rand_operand());
        end
        add_insn(6'd30 + 6'($urandom_range(0, 6)), rand_operand());
        add_insn(OP_EXIT, rand_operand());
        add_insn(6'd63, '1);
        add_insn(6'd38, 64'd0);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (insn_q.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid && status_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && status_q.size() == 0) begin
            $display("[stack_vm_instruction_executor_core] OK");
        end else begin
            $display("[stack_vm_instruction_executor_core] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/svie_pkg.sv
hdl/svie_mem.sv
hdl/svie_muldiv.sv
hdl/stack_vm_instruction_executor_core.sv
test/tb_stack_vm_instruction_executor_core.sv
